FILE: src/vibrato_modulated_delay_assert.svh
// assertion helpers shared by the vibrato block
`ifndef VIBRATO_MODULATED_DELAY_ASSERT_SVH
`define VIBRATO_MODULATED_DELAY_ASSERT_SVH

// same-cycle implication
`define VMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vibrato check failed");

// next-cycle implication
`define VMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vibrato check failed");

`endif

FILE: src/vmd_pkg.sv
`default_nettype none

package vmd_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned WAVE_W     = 25;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned IP_W       = WAVE_W - FRAC_W;
  localparam int unsigned TADDR_W    = 14;
  localparam int unsigned DLEN_W     = 10;
  localparam int unsigned TLEN_W     = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned DLEN_MIN   = 2;
  localparam int unsigned TLEN_MIN   = 1;
  localparam int unsigned GAIN_FULL  = 65536;

  localparam int unsigned DELAY_LENGTH_RST = 241;
  localparam int unsigned TABLE_LENGTH_RST = 9600;
  localparam int unsigned DEPTH_GAIN_RST   = 32768;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_GAIN   = 2'd2;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TABLE  = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic                       channel;
    logic                       frame_end;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [TADDR_W-1:0]         table_addr;
    logic [WAVE_W-1:0]          table_value;
  } vmd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       channel_out;
    logic                       frame_end_out;
  } vmd_out_t;

endpackage

`default_nettype wire

FILE: src/vibrato_modulated_delay.sv
// flow: an accepted sample passes S_GAIN, S_SUM, S_RDB, S_MULT and S_OUT; S_DIV and S_RDA
//   come after S_SUM when write position plus tap delay reaches twice the line length
//   (S_DIV divides the SW = clog2(DELAY_DEPTH+512) bit sum); table writes are done in S_IDLE
// a new sample is taken only in S_IDLE, after S_OUT, which waits while a result is stalled;
//   the sequencer shares the single read port of the delay memory between the two taps
// reset: control state clears at once, then delay memory is swept to zero with input stalled
`default_nettype none
`include "vibrato_modulated_delay_assert.svh"

module vibrato_modulated_delay
  import vmd_pkg::*;
#(
  parameter int unsigned CHANNELS    = 2,
  parameter int unsigned DELAY_DEPTH = 512,
  parameter int unsigned TABLE_DEPTH = 16384
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  vmd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output vmd_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PW       = $clog2(DELAY_DEPTH);
  localparam int unsigned LW       = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned SW       = $clog2(DELAY_DEPTH + (1 << IP_W));
  localparam int unsigned CW       = $clog2(SW + 1);
  localparam int unsigned DLY_SIZE = CHANNELS * DELAY_DEPTH;
  localparam int unsigned AW       = $clog2(DLY_SIZE);
  localparam int unsigned TW       = $clog2(TABLE_DEPTH);
  localparam int unsigned TLW      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MUL_W    = GAIN_W + WAVE_W;
  localparam int unsigned PROD_W   = FRAC_W + 1 + SAMPLE_W + 1;
  localparam int unsigned DLEN_RST =
    (DELAY_LENGTH_RST > DELAY_DEPTH) ? DELAY_DEPTH : DELAY_LENGTH_RST;
  localparam int unsigned TLEN_RST =
    (TABLE_LENGTH_RST > TABLE_DEPTH) ? TABLE_DEPTH : TABLE_LENGTH_RST;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_GAIN  = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_RDA   = 9'b000100000,
    S_RDB   = 9'b001000000,
    S_MULT  = 9'b010000000,
    S_OUT   = 9'b100000000
  } vmd_state_e;

  function automatic logic [AW-1:0] dly_addr(input logic ch, input logic [PW-1:0] idx);
    return AW'(32'(ch) * DELAY_DEPTH + 32'(idx));
  endfunction

  // control state
  vmd_state_e          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [PW-1:0]       wp_q, wp_d;
  logic [TW-1:0]       tp_q, tp_d;
  logic [LW-1:0]       len_q, len_d;
  logic [TLW-1:0]      tlen_q, tlen_d;
  logic [GAIN_W-1:0]   gain_q, gain_d;
  logic [AW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [CW-1:0]       cnt_q, cnt_d;

  // datapath registers
  vmd_in_t                    item_q, item_d;
  logic [WAVE_W-1:0]          d_q, d_d;
  logic [PW-1:0]              ia_q, ia_d;
  logic [SW-1:0]              sum_q, sum_d;
  logic [LW-1:0]              rem_q, rem_d;
  logic signed [SAMPLE_W-1:0] a_q, a_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  vmd_out_t                   out_q, out_d;

  // memory ports
  logic                dly_we;
  logic [AW-1:0]       dly_waddr, dly_raddr;
  logic [SAMPLE_W-1:0] dly_wdata, dly_rdata;
  logic                wave_we;
  logic [WAVE_W-1:0]   wave_rdata;

  // combinational helpers
  logic [MUL_W-1:0]           mul_w;
  logic [SW-1:0]              sum_w;
  logic                       fast_w;
  logic [PW-1:0]              ia_fast_w;
  logic [PW-1:0]              ib_w;
  logic [LW:0]                t_w;
  logic signed [SAMPLE_W:0]   diff_w;
  logic signed [PROD_W-1:0]   prod_w;
  logic signed [PROD_W-1:0]   acc_w;
  logic                       round_up_w;
  logic [SAMPLE_W-1:0]        res_w;
  logic                       ch_ok_w;
  logic                       in_addr_ok_w;
  logic                       smp_accept_w;
  int unsigned                dlen_w, tlen_w, gain_w;

  vmd_ram #(.WIDTH(SAMPLE_W), .DEPTH(DLY_SIZE)) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  vmd_ram #(.WIDTH(WAVE_W), .DEPTH(TABLE_DEPTH)) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (wave_we),
    .waddr_i (TW'(in_data_i.table_addr)),
    .wdata_i (in_data_i.table_value),
    .raddr_i (tp_q),
    .rdata_o (wave_rdata)
  );

  assign ch_ok_w      = 32'(item_q.channel) < CHANNELS;
  assign in_addr_ok_w = 32'(in_data_i.table_addr) < TABLE_DEPTH;
  assign smp_accept_w = in_valid_i && !in_stall_o && in_data_i.mode == MODE_SAMPLE;

  // delay in Q9.16 from gain times table entry
  assign mul_w = MUL_W'(gain_q) * MUL_W'(wave_rdata);

  // tap position: fast path when the sum is below twice the length
  assign sum_w     = SW'(wp_q) + SW'(d_q[FRAC_W +: IP_W]);
  assign fast_w    = 32'(sum_w) < 32'(len_q) * 2;
  assign ia_fast_w = (32'(sum_w) >= 32'(len_q)) ? PW'(32'(sum_w) - 32'(len_q))
                                                 : PW'(sum_w);
  assign ib_w      = (32'(ia_q) + 1 == 32'(len_q)) ? '0 : PW'(32'(ia_q) + 1);
  assign t_w       = {rem_q, sum_q[SW-1]};

  // interpolation, truncated toward zero
  assign diff_w     = {dly_rdata[SAMPLE_W-1], dly_rdata} - {a_q[SAMPLE_W-1], a_q};
  assign prod_w     = PROD_W'($signed({1'b0, d_q[FRAC_W-1:0]})) * PROD_W'(diff_w);
  assign acc_w      = (PROD_W'(a_q) <<< FRAC_W) + prod_q;
  assign round_up_w = acc_w[PROD_W-1] && (acc_w[FRAC_W-1:0] != '0);
  assign res_w      = SAMPLE_W'(acc_w[PROD_W-1:FRAC_W] + (PROD_W - FRAC_W)'(round_up_w));

  assign dlen_w = 32'(cfg_data_i[DLEN_W-1:0]);
  assign tlen_w = 32'(cfg_data_i[TLEN_W-1:0]);
  assign gain_w = 32'(cfg_data_i[GAIN_W-1:0]);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    wp_d        = wp_q;
    tp_d        = tp_q;
    len_d       = len_q;
    tlen_d      = tlen_q;
    gain_d      = gain_q;
    clr_cnt_d   = clr_cnt_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    d_d         = d_q;
    ia_d        = ia_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    a_d         = a_q;
    prod_d      = prod_q;
    out_d       = out_q;
    dly_we      = 1'b0;
    dly_waddr   = dly_addr(item_q.channel, wp_q);
    dly_wdata   = item_q.sample_in;
    dly_raddr   = dly_addr(item_q.channel, ia_q);
    wave_we     = 1'b0;
    in_stall_o  = 1'b1;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // lengths are clamped as they are written
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DELAY_LENGTH: begin
          if (dlen_w < DLEN_MIN) len_d = LW'(DLEN_MIN);
          else if (dlen_w > DELAY_DEPTH) len_d = LW'(DELAY_DEPTH);
          else len_d = LW'(dlen_w);
        end
        CFG_TABLE_LENGTH: begin
          if (tlen_w < TLEN_MIN) tlen_d = TLW'(TLEN_MIN);
          else if (tlen_w > TABLE_DEPTH) tlen_d = TLW'(TABLE_DEPTH);
          else tlen_d = TLW'(tlen_w);
        end
        CFG_DEPTH_GAIN: begin
          gain_d = (gain_w > GAIN_FULL) ? GAIN_W'(GAIN_FULL) : GAIN_W'(gain_w);
        end
        default: ;
      endcase
    end

    case (state_q)
      S_CLEAR: begin
        dly_we    = 1'b1;
        dly_waddr = clr_cnt_q;
        dly_wdata = '0;
        if (32'(clr_cnt_q) == DLY_SIZE - 1) begin
          state_d = S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.mode == MODE_TABLE) begin
            wave_we = in_addr_ok_w;
          end else begin
            state_d = S_GAIN;
          end
        end
      end
      S_GAIN: begin
        d_d     = mul_w[FRAC_W +: WAVE_W];
        state_d = S_SUM;
      end
      S_SUM: begin
        if (fast_w) begin
          ia_d      = ia_fast_w;
          dly_raddr = dly_addr(item_q.channel, ia_fast_w);
          state_d   = S_RDB;
        end else begin
          sum_d   = sum_w;
          rem_d   = '0;
          cnt_d   = CW'(SW);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring remainder, one bit per cycle
        rem_d = (t_w >= {1'b0, len_q}) ? LW'(t_w - {1'b0, len_q}) : LW'(t_w);
        sum_d = sum_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = S_RDA;
        end
      end
      S_RDA: begin
        ia_d      = PW'(rem_q);
        dly_raddr = dly_addr(item_q.channel, PW'(rem_q));
        state_d   = S_RDB;
      end
      S_RDB: begin
        a_d       = dly_rdata;
        dly_raddr = dly_addr(item_q.channel, ib_w);
        state_d   = S_MULT;
      end
      S_MULT: begin
        prod_d  = prod_w;
        dly_we  = ch_ok_w;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.sample_out    = ch_ok_w ? res_w : '0;
          out_d.channel_out   = item_q.channel;
          out_d.frame_end_out = item_q.frame_end;
          out_valid_d         = 1'b1;
          if (item_q.frame_end) begin
            wp_d = (32'(wp_q) + 1 >= 32'(len_q)) ? '0 : PW'(32'(wp_q) + 1);
            tp_d = (32'(tp_q) + 1 >= 32'(tlen_q)) ? '0 : TW'(32'(tp_q) + 1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      tp_q        <= '0;
      len_q       <= LW'(DLEN_RST);
      tlen_q      <= TLW'(TLEN_RST);
      gain_q      <= GAIN_W'(DEPTH_GAIN_RST);
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wp_q        <= wp_d;
      tp_q        <= tp_d;
      len_q       <= len_d;
      tlen_q      <= tlen_d;
      gain_q      <= gain_d;
      clr_cnt_q   <= clr_cnt_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    d_q    <= d_d;
    ia_q   <= ia_d;
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    a_q    <= a_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  `VMD_ASSERT_SAME(a_rem_in_range, clk_i, rst_ni, state_q == S_RDA, rem_q < len_q)
  `VMD_ASSERT_SAME(a_tap_in_range, clk_i, rst_ni, state_q == S_RDB, 32'(ia_q) < 32'(len_q))
  `VMD_ASSERT_SAME(a_result_from_out, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_OUT)
  `VMD_ASSERT_NEXT(a_sample_starts, clk_i, rst_ni, smp_accept_w, state_q == S_GAIN)

endmodule

`default_nettype wire

FILE: src/vmd_ram.sv
`default_nettype none

module vmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
